// ----- hdl/dofq_pkg.sv -----
`timescale 1ns / 1ps
// Package for the drop-oldest frame queue: field widths, codes, state and descriptor types.
// Used by the channel interfaces and the top level.
package dofq_pkg;

   localparam int DEPTH_DEFAULT    = 16;
   localparam int DISC_BIT_DEFAULT = 0;

   localparam int MODE_W      = 2;
   localparam int HANDLE_W    = 32;
   localparam int LENGTH_W    = 16;
   localparam int FLAGS_W     = 8;
   localparam int KIND_W      = 3;
   localparam int QFRAMES_W   = 5;
   localparam int QBYTES_W    = 20;
   localparam int STAT_W      = 32;
   localparam int DBYTES_W    = 48;
   localparam int MAXF_W      = 5;
   localparam int MAXB_W      = 20;
   localparam int CSR_DATA_W  = 20;
   localparam int CSR_INDEX_W = 1;

   localparam logic [MODE_W-1:0] MODE_PUBLISH = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLOSE   = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_FRAMES = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_BYTES  = 1'd1;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACCEPTED = 3'd0,
      KIND_IGNORED  = 3'd1,
      KIND_DROPPED  = 3'd2,
      KIND_READ     = 3'd3,
      KIND_EMPTY    = 3'd4,
      KIND_CLOSED   = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_DROP,
      ST_PUSH,
      ST_CHECK,
      ST_READ
   } state_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [LENGTH_W-1:0] length;
      logic [FLAGS_W-1:0]  flags;
   } desc_type;

endpackage

// ----- hdl/dofq_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response words of the frame queue.
// Depends on dofq_pkg for the field widths.
interface dofq_req_if import dofq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [HANDLE_W-1:0] frame_handle;
   logic [LENGTH_W-1:0] frame_length;
   logic [FLAGS_W-1:0]  frame_flags;

   modport source (output valid, mode, frame_handle, frame_length, frame_flags,
                   input ready);
   modport sink (input valid, mode, frame_handle, frame_length, frame_flags,
                 output ready);
endinterface

interface dofq_rsp_if import dofq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    kind;
   logic [HANDLE_W-1:0]  out_handle;
   logic [LENGTH_W-1:0]  out_length;
   logic [FLAGS_W-1:0]   out_flags;
   logic                 last;
   logic [QFRAMES_W-1:0] held_frames;
   logic [QBYTES_W-1:0]  held_bytes;
   logic [STAT_W-1:0]    published_count;
   logic [STAT_W-1:0]    read_count;
   logic [STAT_W-1:0]    dropped_count;
   logic [DBYTES_W-1:0]  dropped_byte_total;
   logic                 is_closed;

   modport source (output valid, kind, out_handle, out_length, out_flags, last,
                   held_frames, held_bytes, published_count, read_count,
                   dropped_count, dropped_byte_total, is_closed,
                   input ready);
   modport sink (input valid, kind, out_handle, out_length, out_flags, last,
                 held_frames, held_bytes, published_count, read_count,
                 dropped_count, dropped_byte_total, is_closed,
                 output ready);
endinterface

// ----- hdl/dofq_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
// Standalone; no package needed.
module dofq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/drop_oldest_frame_queue.sv -----
`timescale 1ns / 1ps
// Drop-oldest frame descriptor queue. One request word is handled at a time: a close
// responds from dispatch, a read reads the slot RAM then responds, a publish writes the RAM
// then checks limits, and each dropped frame adds a slot RAM read, then its response.
// The next word is accepted in the cycle the last response can first be taken.
// Reset is synchronous and active high; it empties the queue and clears limits and
// statistics, while the slot RAM keeps its contents.
module drop_oldest_frame_queue import dofq_pkg::*; #(
   parameter int DEPTH    = DEPTH_DEFAULT,
   parameter int DISC_BIT = DISC_BIT_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   dofq_req_if.sink               req_ch,
   dofq_rsp_if.source             rsp_ch,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int BYTES_W = $clog2(DEPTH * (2 ** LENGTH_W - 1) + 1);
   localparam int CMPF_W  = (CNT_W > MAXF_W) ? CNT_W : MAXF_W;
   localparam int CMPB_W  = (BYTES_W > MAXB_W) ? BYTES_W : MAXB_W;
   localparam int DESC_W  = $bits(desc_type);
   localparam logic [FLAGS_W-1:0] DISC_MASK = FLAGS_W'(1) << DISC_BIT;

   state_type state_ff, state_in;

   logic [MODE_W-1:0] req_mode_ff;
   desc_type          req_desc_ff;

   logic [IDX_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [BYTES_W-1:0]  bytes_ff, bytes_in;
   logic                closed_ff, closed_in;
   logic                disc_ff, disc_in;
   logic                pre_push_ff, pre_push_in;
   logic                dropped_any_ff, dropped_any_in;
   logic [STAT_W-1:0]   pub_ff, pub_in;
   logic [STAT_W-1:0]   rd_cnt_ff, rd_cnt_in;
   logic [STAT_W-1:0]   drop_cnt_ff, drop_cnt_in;
   logic [DBYTES_W-1:0] dbytes_ff, dbytes_in;
   logic [MAXF_W-1:0]   max_frames_ff;
   logic [MAXB_W-1:0]   max_bytes_ff;

   logic                 rsp_valid_ff;
   kind_type             rsp_kind_ff;
   desc_type             rsp_desc_ff;
   logic                 rsp_last_ff;
   logic [QFRAMES_W-1:0] rsp_qframes_ff;
   logic [QBYTES_W-1:0]  rsp_qbytes_ff;
   logic [STAT_W-1:0]    rsp_pub_ff;
   logic [STAT_W-1:0]    rsp_rd_ff;
   logic [STAT_W-1:0]    rsp_drop_ff;
   logic [DBYTES_W-1:0]  rsp_dbytes_ff;
   logic                 rsp_closed_ff;

   logic             req_accept;
   logic             out_free;
   logic             over_limit;
   logic             over_any;
   logic             queue_full;
   logic [IDX_W:0]   tail_sum;
   logic [IDX_W-1:0] tail_idx;
   logic [IDX_W-1:0] head_next;

   logic             ram_wr_en;
   logic             ram_rd_en;
   logic [DESC_W-1:0] ram_rd_data;
   desc_type          pop_desc;

   logic     emit;
   kind_type emit_kind;
   desc_type emit_desc;
   logic     emit_last;
   logic     do_push;
   logic     do_pop;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign over_limit = ((max_frames_ff != '0) && (CMPF_W'(count_ff) > CMPF_W'(max_frames_ff)))
                    || ((max_bytes_ff != '0) && (CMPB_W'(bytes_ff) > CMPB_W'(max_bytes_ff)));
   assign over_any   = (count_ff != '0) && over_limit;
   assign queue_full = (count_ff == CNT_W'(DEPTH));

   // Tail is head plus occupancy, wrapped once; head stays below DEPTH and occupancy at most DEPTH.
   assign tail_sum  = (IDX_W+1)'(head_ff) + (IDX_W+1)'(count_ff);
   assign tail_idx  = (tail_sum >= (IDX_W+1)'(DEPTH)) ? IDX_W'(tail_sum - (IDX_W+1)'(DEPTH))
                                                     : IDX_W'(tail_sum);
   assign head_next = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;

   // The discontinuity mark of the head entry lives in a flag register and is merged in
   // when that entry leaves the queue, which saves a read-modify-write of the RAM.
   always_comb begin
      pop_desc       = desc_type'(ram_rd_data);
      pop_desc.flags = pop_desc.flags | (disc_ff ? DISC_MASK : '0);
   end

   dofq_ram #(
      .WIDTH(DESC_W),
      .DEPTH(DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_idx),
      .wr_data (req_desc_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            case (req_mode_ff)
               MODE_PUBLISH: begin
                  if (closed_ff) begin
                     if (out_free) state_in = ST_IDLE;
                  end else if (queue_full) begin
                     state_in = ST_DROP;
                  end else begin
                     state_in = ST_CHECK;
                  end
               end
               MODE_READ: begin
                  if (count_ff != '0) begin
                     state_in = ST_READ;
                  end else if (out_free) begin
                     state_in = ST_IDLE;
                  end
               end
               MODE_CLOSE: begin
                  if (out_free) state_in = ST_IDLE;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_DROP: begin
            if (out_free) state_in = pre_push_ff ? ST_PUSH : ST_CHECK;
         end
         ST_PUSH: state_in = ST_CHECK;
         ST_CHECK: begin
            if (over_any) begin
               state_in = ST_DROP;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath actions and register updates per state.
   always_comb begin
      head_in        = head_ff;
      count_in       = count_ff;
      bytes_in       = bytes_ff;
      closed_in      = closed_ff;
      disc_in        = disc_ff;
      pre_push_in    = pre_push_ff;
      dropped_any_in = dropped_any_ff;
      pub_in         = pub_ff;
      rd_cnt_in      = rd_cnt_ff;
      drop_cnt_in    = drop_cnt_ff;
      dbytes_in      = dbytes_ff;
      ram_wr_en      = 1'b0;
      ram_rd_en      = 1'b0;
      emit           = 1'b0;
      emit_kind      = KIND_ACCEPTED;
      emit_desc      = req_desc_ff;
      emit_last      = 1'b0;
      do_push        = 1'b0;
      do_pop         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) dropped_any_in = 1'b0;
         end
         ST_DISPATCH: begin
            case (req_mode_ff)
               MODE_PUBLISH: begin
                  if (closed_ff) begin
                     if (out_free) begin
                        emit      = 1'b1;
                        emit_kind = KIND_IGNORED;
                        emit_last = 1'b1;
                     end
                  end else if (queue_full) begin
                     ram_rd_en   = 1'b1;
                     pre_push_in = 1'b1;
                  end else begin
                     do_push     = 1'b1;
                     pre_push_in = 1'b0;
                  end
               end
               MODE_READ: begin
                  if (count_ff != '0) begin
                     ram_rd_en = 1'b1;
                  end else if (out_free) begin
                     emit      = 1'b1;
                     emit_kind = KIND_EMPTY;
                     emit_desc = '0;
                     emit_last = 1'b1;
                  end
               end
               MODE_CLOSE: begin
                  if (out_free) begin
                     closed_in = 1'b1;
                     head_in   = '0;
                     count_in  = '0;
                     bytes_in  = '0;
                     disc_in   = 1'b0;
                     emit      = 1'b1;
                     emit_kind = KIND_CLOSED;
                     emit_desc = '0;
                     emit_last = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         ST_DROP: begin
            if (out_free) begin
               do_pop         = 1'b1;
               drop_cnt_in    = drop_cnt_ff + 1'b1;
               dbytes_in      = dbytes_ff + DBYTES_W'(pop_desc.length);
               dropped_any_in = 1'b1;
               emit           = 1'b1;
               emit_kind      = KIND_DROPPED;
               emit_desc      = pop_desc;
            end
         end
         ST_PUSH: do_push = 1'b1;
         ST_CHECK: begin
            if (over_any) begin
               ram_rd_en   = 1'b1;
               pre_push_in = 1'b0;
            end else if (out_free) begin
               if (dropped_any_ff && (count_ff != '0)) disc_in = 1'b1;
               emit      = 1'b1;
               emit_kind = KIND_ACCEPTED;
               emit_last = 1'b1;
            end
         end
         ST_READ: begin
            if (out_free) begin
               do_pop    = 1'b1;
               rd_cnt_in = rd_cnt_ff + 1'b1;
               emit      = 1'b1;
               emit_kind = KIND_READ;
               emit_desc = pop_desc;
               emit_last = 1'b1;
            end
         end
         default: ;
      endcase

      if (do_push) begin
         ram_wr_en = 1'b1;
         count_in  = count_ff + 1'b1;
         bytes_in  = bytes_ff + BYTES_W'(req_desc_ff.length);
         pub_in    = pub_ff + 1'b1;
      end
      if (do_pop) begin
         head_in  = head_next;
         count_in = count_ff - 1'b1;
         bytes_in = bytes_ff - BYTES_W'(pop_desc.length);
         disc_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         head_ff        <= '0;
         count_ff       <= '0;
         bytes_ff       <= '0;
         closed_ff      <= 1'b0;
         disc_ff        <= 1'b0;
         pre_push_ff    <= 1'b0;
         dropped_any_ff <= 1'b0;
         pub_ff         <= '0;
         rd_cnt_ff      <= '0;
         drop_cnt_ff    <= '0;
         dbytes_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         head_ff        <= head_in;
         count_ff       <= count_in;
         bytes_ff       <= bytes_in;
         closed_ff      <= closed_in;
         disc_ff        <= disc_in;
         pre_push_ff    <= pre_push_in;
         dropped_any_ff <= dropped_any_in;
         pub_ff         <= pub_in;
         rd_cnt_ff      <= rd_cnt_in;
         drop_cnt_ff    <= drop_cnt_in;
         dbytes_ff      <= dbytes_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frames_ff <= '0;
         max_bytes_ff  <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MAX_FRAMES: max_frames_ff <= csr_wdata[MAXF_W-1:0];
            CSR_MAX_BYTES:  max_bytes_ff  <= csr_wdata[MAXB_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_mode_ff        <= req_ch.mode;
         req_desc_ff.handle <= req_ch.frame_handle;
         req_desc_ff.length <= req_ch.frame_length;
         req_desc_ff.flags  <= req_ch.frame_flags;
      end
   end

   // The response word carries the statistics as they stand after this word's update.
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff    <= emit_kind;
         rsp_desc_ff    <= emit_desc;
         rsp_last_ff    <= emit_last;
         rsp_qframes_ff <= QFRAMES_W'(count_in);
         rsp_qbytes_ff  <= QBYTES_W'(bytes_in);
         rsp_pub_ff     <= pub_in;
         rsp_rd_ff      <= rd_cnt_in;
         rsp_drop_ff    <= drop_cnt_in;
         rsp_dbytes_ff  <= dbytes_in;
         rsp_closed_ff  <= closed_in;
      end
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.kind               = rsp_kind_ff;
   assign rsp_ch.out_handle         = rsp_desc_ff.handle;
   assign rsp_ch.out_length         = rsp_desc_ff.length;
   assign rsp_ch.out_flags          = rsp_desc_ff.flags;
   assign rsp_ch.last               = rsp_last_ff;
   assign rsp_ch.held_frames        = rsp_qframes_ff;
   assign rsp_ch.held_bytes         = rsp_qbytes_ff;
   assign rsp_ch.published_count    = rsp_pub_ff;
   assign rsp_ch.read_count         = rsp_rd_ff;
   assign rsp_ch.dropped_count      = rsp_drop_ff;
   assign rsp_ch.dropped_byte_total = rsp_dbytes_ff;
   assign rsp_ch.is_closed          = rsp_closed_ff;

endmodule
